// ===== hw/rtl/cpa_pkg.sv =====
`default_nettype none
package cpa_pkg;

   localparam int GainWidth  = 48;
   localparam int AccWidth   = 48;
   localparam int IntWidth   = 32;
   localparam int OutWidth   = 24;

   localparam logic [47:0] GainsReset       = 48'd0;
   localparam logic [31:0] PitchLimitsReset = 32'd104921536;
   localparam logic [13:0] RollLimitReset   = 14'd2880;

   localparam logic signed [17:0] HdgHalfTurn   = 18'sd11520;
   localparam logic signed [17:0] HdgFullTurn   = 18'sd23040;
   localparam logic signed [17:0] RollDeadband  = 18'sd128;
   localparam logic signed [17:0] RudderWindow  = 18'sd320;
   localparam logic signed [17:0] SlewThreshold = 18'sd19;
   localparam logic signed [17:0] SlewStep      = 18'sd13;

   // Register indexes on the configuration port.
   localparam logic [2:0] RegRollGains   = 3'd0;
   localparam logic [2:0] RegPitchGains  = 3'd1;
   localparam logic [2:0] RegYawGains    = 3'd2;
   localparam logic [2:0] RegAltGains    = 3'd3;
   localparam logic [2:0] RegHdgGains    = 3'd4;
   localparam logic [2:0] RegPitchLimits = 3'd5;
   localparam logic [2:0] RegRollLimit   = 3'd6;
   localparam logic [2:0] RegEngageMode  = 3'd7;

   // Command to the shared PID unit.
   typedef struct packed {
      logic                start;
      logic [47:0]         gains;
      logic signed [17:0]  err;
      logic signed [31:0]  integ;
      logic signed [17:0]  prev_err;
   } pid_cmd_type;

   // Status back from the shared PID unit.
   typedef struct packed {
      logic                done;
      logic signed [31:0]  integ;
      logic signed [35:0]  result;
   } pid_rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/cpa_pid_unit.sv =====
`default_nettype none
module cpa_pid_unit
   import cpa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire pid_cmd_type cmd,
   output pid_rsp_type      rsp
);

   localparam logic [2:0] PStIdle = 3'd0;
   localparam logic [2:0] PStKi   = 3'd1;
   localparam logic [2:0] PStKp   = 3'd2;
   localparam logic [2:0] PStKd   = 3'd3;
   localparam logic [2:0] PStDone = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic signed [16:0]       mul_a;
   logic signed [18:0]       mul_b;
   logic signed [35:0]       prod_ff;
   logic signed [AccWidth-1:0] acc_ff, acc_in;
   logic signed [31:0]       integ_ff, integ_in;
   logic signed [AccWidth-1:0] isum;
   logic signed [15:0]       kp, ki, kd;
   logic                     prod_valid_ff;

   assign kp = cmd.gains[47:32];
   assign ki = cmd.gains[31:16];
   assign kd = cmd.gains[15:0];

   // One multiplier, fed one gain per cycle.
   always_comb begin
      mul_a = 17'(ki);
      mul_b = 19'(cmd.err);
      case (state_ff)
         PStKi: begin
            mul_a = 17'(ki);
            mul_b = 19'(cmd.err);
         end
         PStKp: begin
            mul_a = 17'(kp);
            mul_b = 19'(cmd.err);
         end
         PStKd: begin
            mul_a = 17'(kd);
            mul_b = 19'(cmd.err) - 19'(cmd.prev_err);
         end
         default: begin
            mul_a = 17'(ki);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 36'(mul_a * mul_b);
   end

   assign isum = AccWidth'(integ_ff) + AccWidth'(prod_ff);

   // Sequencer: Ki product, saturate integrator, then add Kp and Kd terms.
   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      integ_in = integ_ff;
      case (state_ff)
         PStIdle: begin
            if (cmd.start) begin
               state_in = PStKi;
               integ_in = cmd.integ;
            end
         end
         PStKi: state_in = PStKp;
         PStKp: begin
            if (isum > AccWidth'(32'sh7fffffff)) integ_in = 32'sh7fffffff;
            else if (isum < -AccWidth'(64'sh80000000)) integ_in = 32'sh80000000;
            else integ_in = isum[31:0];
            state_in = PStKd;
         end
         PStKd: begin
            acc_in   = AccWidth'(integ_ff) + AccWidth'(prod_ff);
            state_in = PStDone;
         end
         PStDone: begin
            acc_in   = acc_ff + AccWidth'(prod_ff);
            state_in = PStIdle;
         end
         default: state_in = PStIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= PStIdle;
         prod_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prod_valid_ff <= (state_ff == PStDone);
      end
      acc_ff   <= acc_in;
      integ_ff <= integ_in;
   end

   // Floor division by 4096 is an arithmetic shift.
   assign rsp.done   = prod_valid_ff && (state_ff == PStIdle);
   assign rsp.integ  = integ_ff;
   assign rsp.result = 36'(acc_ff >>> 12);

endmodule
`default_nettype wire

// ===== hw/rtl/cpa_regs.sv =====
`default_nettype none
module cpa_regs
   import cpa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [47:0] csr_data,
   output logic [47:0]      roll_gains,
   output logic [47:0]      pitch_gains,
   output logic [47:0]      yaw_gains,
   output logic [47:0]      alt_gains,
   output logic [47:0]      hdg_gains,
   output logic [31:0]      pitch_limits,
   output logic [13:0]      roll_limit,
   output logic             engage_mode
);

   logic [47:0] roll_ff, pitch_ff, yaw_ff, alt_ff, hdg_ff;
   logic [31:0] plim_ff;
   logic [13:0] rlim_ff;
   logic        mode_ff;

   assign csr_ready = 1'b1;

   // Register file, written on each transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         roll_ff  <= GainsReset;
         pitch_ff <= GainsReset;
         yaw_ff   <= GainsReset;
         alt_ff   <= GainsReset;
         hdg_ff   <= GainsReset;
         plim_ff  <= PitchLimitsReset;
         rlim_ff  <= RollLimitReset;
         mode_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            RegRollGains:   roll_ff  <= csr_data;
            RegPitchGains:  pitch_ff <= csr_data;
            RegYawGains:    yaw_ff   <= csr_data;
            RegAltGains:    alt_ff   <= csr_data;
            RegHdgGains:    hdg_ff   <= csr_data;
            RegPitchLimits: plim_ff  <= csr_data[31:0];
            RegRollLimit:   rlim_ff  <= csr_data[13:0];
            RegEngageMode:  mode_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign roll_gains   = roll_ff;
   assign pitch_gains  = pitch_ff;
   assign yaw_gains    = yaw_ff;
   assign alt_gains    = alt_ff;
   assign hdg_gains    = hdg_ff;
   assign pitch_limits = plim_ff;
   assign roll_limit   = rlim_ff;
   assign engage_mode  = mode_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/cascaded_pid_autopilot.sv =====
// Each tick runs up to five PID passes in turn on the one shared multiplier (altitude,
// heading, pitch, roll, rudder), then presents the result; the altitude, heading and
// rudder passes may be skipped, and in manual mode a tick goes straight to the result.
// Flow control: one tick at a time; req_ready is low from acceptance until the result is taken.
// Reset: synchronous, active high; clears all loop state and loads register defaults.
`default_nettype none
module cascaded_pid_autopilot
   import cpa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [47:0]        csr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_pitch_meas,
   input  wire logic signed [15:0] req_roll_meas,
   input  wire logic [14:0]        req_heading_meas,
   input  wire logic [14:0]        req_bearing_cmd,
   input  wire logic [15:0]        req_altitude_meas,
   input  wire logic [15:0]        req_altitude_cmd,
   input  wire logic               req_nav_valid,
   input  wire logic               req_alt_cmd_valid,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [23:0]      rsp_pitch_stick,
   output logic signed [23:0]      rsp_roll_stick,
   output logic signed [23:0]      rsp_rudder_cmd,
   output logic                    rsp_active
);

   localparam logic [3:0] StIdle  = 4'd0;
   localparam logic [3:0] StAltGo = 4'd1;
   localparam logic [3:0] StAltWt = 4'd2;
   localparam logic [3:0] StHdgGo = 4'd3;
   localparam logic [3:0] StHdgWt = 4'd4;
   localparam logic [3:0] StPitGo = 4'd5;
   localparam logic [3:0] StPitWt = 4'd6;
   localparam logic [3:0] StRolGo = 4'd7;
   localparam logic [3:0] StRolWt = 4'd8;
   localparam logic [3:0] StYawGo = 4'd9;
   localparam logic [3:0] StYawWt = 4'd10;
   localparam logic [3:0] StOut   = 4'd11;

   logic [47:0] roll_gains, pitch_gains, yaw_gains, alt_gains, hdg_gains;
   logic [31:0] pitch_limits;
   logic [13:0] roll_limit;
   logic        engage_mode;

   logic [3:0] state_ff;

   // Captured item.
   logic signed [15:0] pmeas_ff, rmeas_ff;
   logic [15:0]        ameas_ff, acmd_ff;
   logic               nav_ff, altok_ff;
   logic signed [17:0] hdg_err_ff;

   // Loop state.
   logic signed [31:0] alt_i_ff, hdg_i_ff, pit_i_ff, rol_i_ff, yaw_i_ff;
   logic signed [17:0] alt_e_ff, pit_e_ff, rol_e_ff;
   logic signed [15:0] hdg_e_ff, yaw_e_ff;
   logic signed [15:0] ptgt_ff, rtgt_ff, slew_ff;

   logic signed [23:0] pstick_ff, rstick_ff, rudder_ff;
   logic               active_ff;

   pid_cmd_type cmd;
   pid_rsp_type prsp;

   logic signed [17:0] raw_err, slew_next, sdiff;
   logic signed [35:0] r;
   logic signed [35:0] pmax, pmin, rl;
   logic               in_window;

   cpa_regs u_regs (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .roll_gains, .pitch_gains, .yaw_gains, .alt_gains, .hdg_gains,
      .pitch_limits, .roll_limit, .engage_mode
   );

   cpa_pid_unit u_pid (.clock, .reset, .cmd, .rsp(prsp));

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = (state_ff == StOut);
   assign rsp_pitch_stick = pstick_ff;
   assign rsp_roll_stick  = rstick_ff;
   assign rsp_rudder_cmd  = rudder_ff;
   assign rsp_active      = active_ff;

   assign raw_err = 18'($signed({3'b0, req_bearing_cmd})) - 18'($signed({3'b0, req_heading_meas}));
   assign sdiff   = 18'(rtgt_ff) - 18'(slew_ff);
   assign slew_next = (sdiff > SlewThreshold)  ? 18'(slew_ff) + SlewStep :
                      (sdiff < -SlewThreshold) ? 18'(slew_ff) - SlewStep : 18'(rtgt_ff);
   assign in_window = !(hdg_err_ff > RudderWindow || hdg_err_ff < -RudderWindow);
   assign r    = prsp.result;
   assign pmax = 36'($signed(pitch_limits[31:16]));
   assign pmin = 36'($signed(pitch_limits[15:0]));
   assign rl   = 36'($signed({1'b0, roll_limit}));

   // Drive the shared unit for the loop in progress.
   always_comb begin
      cmd = '0;
      case (state_ff)
         StAltGo: begin
            cmd.start = 1'b1; cmd.gains = alt_gains;
            cmd.err = 18'($signed({2'b0, acmd_ff})) - 18'($signed({2'b0, ameas_ff}));
            cmd.integ = alt_i_ff; cmd.prev_err = alt_e_ff;
         end
         StAltWt: begin
            cmd.gains = alt_gains;
            cmd.err = 18'($signed({2'b0, acmd_ff})) - 18'($signed({2'b0, ameas_ff}));
            cmd.prev_err = alt_e_ff;
         end
         StHdgGo, StHdgWt: begin
            cmd.start = (state_ff == StHdgGo); cmd.gains = hdg_gains;
            cmd.err = hdg_err_ff; cmd.integ = hdg_i_ff; cmd.prev_err = 18'(hdg_e_ff);
         end
         StPitGo, StPitWt: begin
            cmd.start = (state_ff == StPitGo); cmd.gains = pitch_gains;
            cmd.err = 18'(ptgt_ff) - 18'(pmeas_ff);
            cmd.integ = pit_i_ff; cmd.prev_err = pit_e_ff;
         end
         StRolGo, StRolWt: begin
            cmd.start = (state_ff == StRolGo); cmd.gains = roll_gains;
            cmd.err = 18'(slew_ff) - 18'(rmeas_ff);
            cmd.integ = rol_i_ff; cmd.prev_err = rol_e_ff;
         end
         StYawGo, StYawWt: begin
            cmd.start = (state_ff == StYawGo); cmd.gains = yaw_gains;
            cmd.err = hdg_err_ff; cmd.integ = yaw_i_ff; cmd.prev_err = 18'(yaw_e_ff);
         end
         default: cmd = '0;
      endcase
   end

   // Tick sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         alt_i_ff <= '0; hdg_i_ff <= '0; pit_i_ff <= '0; rol_i_ff <= '0; yaw_i_ff <= '0;
         alt_e_ff <= '0; pit_e_ff <= '0; rol_e_ff <= '0; hdg_e_ff <= '0; yaw_e_ff <= '0;
         ptgt_ff <= '0; rtgt_ff <= '0; slew_ff <= '0;
      end else begin
         case (state_ff)
            StIdle: begin
               if (req_valid) begin
                  pmeas_ff <= req_pitch_meas;
                  rmeas_ff <= req_roll_meas;
                  ameas_ff <= req_altitude_meas;
                  acmd_ff  <= req_altitude_cmd;
                  nav_ff   <= req_nav_valid;
                  altok_ff <= req_alt_cmd_valid;
                  if (raw_err < -HdgHalfTurn) hdg_err_ff <= raw_err + HdgFullTurn;
                  else if (raw_err > HdgHalfTurn) hdg_err_ff <= raw_err - HdgFullTurn;
                  else hdg_err_ff <= raw_err;
                  pstick_ff <= '0; rstick_ff <= '0; rudder_ff <= '0; active_ff <= 1'b0;
                  if (engage_mode) state_ff <= StOut;
                  else if (req_nav_valid && req_alt_cmd_valid) state_ff <= StAltGo;
                  else if (req_nav_valid) state_ff <= StHdgGo;
                  else state_ff <= StPitGo;
               end
            end
            StAltGo: state_ff <= StAltWt;
            StAltWt: if (prsp.done) begin
               alt_i_ff <= prsp.integ;
               alt_e_ff <= cmd.err;
               if (r > pmax) ptgt_ff <= pmax[15:0];
               else if (r < pmin) ptgt_ff <= pmin[15:0];
               else ptgt_ff <= r[15:0];
               state_ff <= StHdgGo;
            end
            StHdgGo: state_ff <= StHdgWt;
            StHdgWt: if (prsp.done) begin
               hdg_i_ff <= prsp.integ;
               hdg_e_ff <= hdg_err_ff[15:0];
               if (r < 36'(RollDeadband) && r > -36'(RollDeadband)) rtgt_ff <= '0;
               else if (r > rl) rtgt_ff <= rl[15:0];
               else if (r < -rl) rtgt_ff <= 16'(-rl);
               else rtgt_ff <= r[15:0];
               state_ff <= StPitGo;
            end
            StPitGo: state_ff <= StPitWt;
            StPitWt: if (prsp.done) begin
               pit_i_ff <= prsp.integ;
               pit_e_ff <= cmd.err;
               if (r > 36'sd8388607) pstick_ff <= 24'sh7fffff;
               else if (r < -36'sd8388608) pstick_ff <= 24'sh800000;
               else pstick_ff <= r[23:0];
               slew_ff  <= slew_next[15:0];
               state_ff <= StRolGo;
            end
            StRolGo: state_ff <= StRolWt;
            StRolWt: if (prsp.done) begin
               rol_i_ff <= prsp.integ;
               rol_e_ff <= cmd.err;
               if (r > 36'sd8388607) rstick_ff <= 24'sh7fffff;
               else if (r < -36'sd8388608) rstick_ff <= 24'sh800000;
               else rstick_ff <= r[23:0];
               active_ff <= 1'b1;
               if (nav_ff && in_window) state_ff <= StYawGo;
               else begin
                  if (nav_ff) yaw_i_ff <= '0;
                  state_ff <= StOut;
               end
            end
            StYawGo: state_ff <= StYawWt;
            StYawWt: if (prsp.done) begin
               yaw_i_ff <= prsp.integ;
               yaw_e_ff <= hdg_err_ff[15:0];
               if (r > 36'sd8388607) rudder_ff <= 24'sh7fffff;
               else if (r < -36'sd8388608) rudder_ff <= 24'sh800000;
               else rudder_ff <= r[23:0];
               state_ff <= StOut;
            end
            StOut: if (rsp_ready) state_ff <= StIdle;
            default: state_ff <= StIdle;
         endcase
      end
   end

   // A new tick is only taken when no result is pending.
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("input and output sides both open");
   // A manual tick reports no activity.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && engage_mode) |=> (rsp_valid && !rsp_active))
      else $error("manual tick produced activity");
   // The rudder is zero whenever the tick had no navigation, so the yaw pass was not flown.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !nav_ff) |-> (rsp_rudder_cmd == 24'sd0))
      else $error("rudder nonzero without navigation");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cpa_pkg::*;

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [47:0]        csr_data;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_pitch_meas;
   logic signed [15:0] req_roll_meas;
   logic [14:0]        req_heading_meas;
   logic [14:0]        req_bearing_cmd;
   logic [15:0]        req_altitude_meas;
   logic [15:0]        req_altitude_cmd;
   logic               req_nav_valid;
   logic               req_alt_cmd_valid;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [23:0] rsp_pitch_stick;
   logic signed [23:0] rsp_roll_stick;
   logic signed [23:0] rsp_rudder_cmd;
   logic               rsp_active;

   typedef struct {
      logic signed [23:0] pitch_stick;
      logic signed [23:0] roll_stick;
      logic signed [23:0] rudder_cmd;
      logic               active;
   } stick_cmd_type;

   typedef struct {
      longint integ;
      longint prev_err;
   } loop_type;

   cascaded_pid_autopilot u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pitch_meas(req_pitch_meas), .req_roll_meas(req_roll_meas),
      .req_heading_meas(req_heading_meas), .req_bearing_cmd(req_bearing_cmd),
      .req_altitude_meas(req_altitude_meas), .req_altitude_cmd(req_altitude_cmd),
      .req_nav_valid(req_nav_valid), .req_alt_cmd_valid(req_alt_cmd_valid),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pitch_stick(rsp_pitch_stick), .rsp_roll_stick(rsp_roll_stick),
      .rsp_rudder_cmd(rsp_rudder_cmd), .rsp_active(rsp_active)
   );

   // Shadow copy of the registers and loop state of the autopilot.
   logic [47:0] gains_q [8];
   logic [31:0] pitch_lim_q;
   logic [13:0] roll_lim_q;
   logic        manual_q;
   loop_type    alt_l, hdg_l, pit_l, rol_l, yaw_l;
   longint      pitch_tgt, roll_tgt, slew_tgt;

   stick_cmd_type expected_cmds[$];
   int          fail_count;
   int          send_idle_pct;
   int          recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint clamp(longint x, longint lo, longint hi);
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   // One PID pass: saturating integrator, output floored by 4096.
   function automatic longint pid_pass(logic [47:0] g, longint e, ref loop_type s);
      longint kp;
      longint ki;
      longint kd;
      longint acc;
      kp = longint'($signed(g[47:32]));
      ki = longint'($signed(g[31:16]));
      kd = longint'($signed(g[15:0]));
      s.integ = clamp(s.integ + ki * e, -64'sd2147483648, 64'sd2147483647);
      acc = kp * e + s.integ + kd * (e - s.prev_err);
      s.prev_err = e;
      return acc >>> 12;
   endfunction

   task automatic reset_model();
      alt_l = '{0, 0}; hdg_l = '{0, 0}; pit_l = '{0, 0};
      rol_l = '{0, 0}; yaw_l = '{0, 0};
      pitch_tgt = 0; roll_tgt = 0; slew_tgt = 0;
      foreach (gains_q[i]) gains_q[i] = GainsReset;
      pitch_lim_q = PitchLimitsReset;
      roll_lim_q = RollLimitReset;
      manual_q = 1'b0;
   endtask

   function automatic stick_cmd_type predict_sticks(
      logic signed [15:0] pm, logic signed [15:0] rm, logic [14:0] hdg,
      logic [14:0] brg, logic [15:0] am, logic [15:0] ac, logic nav, logic alt_ok);
      stick_cmd_type r;
      longint herr;
      longint v;
      longint diff;
      longint pmax;
      longint pmin;
      r = '{0, 0, 0, 1'b0};
      if (manual_q) return r;
      herr = longint'(brg) - longint'(hdg);
      if (herr < -HdgHalfTurn) herr += HdgFullTurn;
      else if (herr > HdgHalfTurn) herr -= HdgFullTurn;
      if (nav && alt_ok) begin
         pmax = longint'($signed(pitch_lim_q[31:16]));
         pmin = longint'($signed(pitch_lim_q[15:0]));
         v = pid_pass(gains_q[RegAltGains], longint'(ac) - longint'(am), alt_l);
         if (v > pmax) v = pmax;
         else if (v < pmin) v = pmin;
         pitch_tgt = v;
      end
      if (nav) begin
         v = pid_pass(gains_q[RegHdgGains], herr, hdg_l);
         if (v < RollDeadband && v > -RollDeadband) v = 0;
         roll_tgt = clamp(v, -longint'(roll_lim_q), longint'(roll_lim_q));
      end
      r.pitch_stick = 24'(clamp(pid_pass(gains_q[RegPitchGains], pitch_tgt - pm, pit_l),
                                -8388608, 8388607));
      diff = roll_tgt - slew_tgt;
      if (diff > SlewThreshold) slew_tgt += SlewStep;
      else if (diff < -SlewThreshold) slew_tgt -= SlewStep;
      else slew_tgt = roll_tgt;
      r.roll_stick = 24'(clamp(pid_pass(gains_q[RegRollGains], slew_tgt - rm, rol_l),
                               -8388608, 8388607));
      if (nav) begin
         if (herr > RudderWindow || herr < -RudderWindow) yaw_l.integ = 0;
         else r.rudder_cmd = 24'(clamp(pid_pass(gains_q[RegYawGains], herr, yaw_l),
                                       -8388608, 8388607));
      end
      r.active = 1'b1;
      return r;
   endfunction

   // Check each result transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cmds.size() == 0) begin
            $error("unexpected result transfer");
            fail_count++;
         end else begin
            stick_cmd_type e;
            e = expected_cmds.pop_front();
            if (rsp_pitch_stick !== e.pitch_stick) begin
               $error("pitch_stick exp %0d got %0d", e.pitch_stick, rsp_pitch_stick);
               fail_count++;
            end
            if (rsp_roll_stick !== e.roll_stick) begin
               $error("roll_stick exp %0d got %0d", e.roll_stick, rsp_roll_stick);
               fail_count++;
            end
            if (rsp_rudder_cmd !== e.rudder_cmd) begin
               $error("rudder_cmd exp %0d got %0d", e.rudder_cmd, rsp_rudder_cmd);
               fail_count++;
            end
            if (rsp_active !== e.active) begin
               $error("active exp %0b got %0b", e.active, rsp_active);
               fail_count++;
            end
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic write_reg(logic [2:0] idx, logic [47:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         RegPitchLimits: pitch_lim_q = data[31:0];
         RegRollLimit:   roll_lim_q = data[13:0];
         RegEngageMode:  manual_q = data[0];
         default:        gains_q[idx] = data;
      endcase
      @(posedge clock);
   endtask

   task automatic send_tick(logic signed [15:0] pm, logic signed [15:0] rm,
                            logic [14:0] hdg, logic [14:0] brg, logic [15:0] am,
                            logic [15:0] ac, logic nav, logic alt_ok);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_pitch_meas <= pm; req_roll_meas <= rm;
      req_heading_meas <= hdg; req_bearing_cmd <= brg;
      req_altitude_meas <= am; req_altitude_cmd <= ac;
      req_nav_valid <= nav; req_alt_cmd_valid <= alt_ok;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_cmds.push_back(predict_sticks(pm, rm, hdg, brg, am, ac, nav, alt_ok));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [47:0] rand_gains(int mag);
      logic [47:0] g;
      for (int i = 0; i < 3; i++)
         g[i*16 +: 16] = 16'($signed($urandom_range(2 * mag)) - mag);
      return g;
   endfunction

   // Headings near each other so the rudder window is exercised.
   task automatic send_random(bit wide);
      logic [14:0] h;
      logic [14:0] b;
      int          off;
      h = 15'($urandom_range(23039));
      off = $urandom_range(3) == 0 ? $urandom_range(23039) : $urandom_range(800);
      b = 15'((h + off - 400 + 23040) % 23040);
      if (wide && $urandom_range(9) == 0) begin
         h = 15'($urandom);
         b = 15'($urandom);
      end
      send_tick(16'($urandom), 16'($urandom), h, b, 16'($urandom), 16'($urandom),
                $urandom_range(7) != 0, $urandom_range(5) != 0);
   endtask

   task automatic test_directed();
      write_reg(RegPitchGains, {16'sd4096, 16'sd100, 16'sd2000});
      write_reg(RegRollGains, {16'sd8192, 16'sd200, 16'sd1000});
      write_reg(RegYawGains, {16'sd4096, 16'sd300, 16'sd500});
      write_reg(RegAltGains, {16'sd2048, 16'sd10, 16'sd50});
      write_reg(RegHdgGains, {16'sd4096, 16'sd20, 16'sd100});
      // Field extremes, heading wrap in both directions, rudder window edges.
      send_tick(16'sh7fff, 16'sh8000, 15'd0, 15'd23039, 16'd0, 16'hffff, 1, 1);
      send_tick(16'sh8000, 16'sh7fff, 15'd23039, 15'd0, 16'hffff, 16'd0, 1, 1);
      send_tick(16'sd0, 16'sd0, 15'd1000, 15'd1320, 16'd100, 16'd100, 1, 1);
      send_tick(16'sd0, 16'sd0, 15'd1000, 15'd1321, 16'd100, 16'd100, 1, 1);
      send_tick(16'sd0, 16'sd0, 15'd1000, 15'd680, 16'd100, 16'd100, 1, 1);
      send_tick(16'sd0, 16'sd0, 15'd1000, 15'd679, 16'd100, 16'd100, 1, 1);
      send_tick(16'sd0, 16'sd0, 15'd0, 15'd11520, 16'd0, 16'd0, 1, 1);
      send_tick(16'sd0, 16'sd0, 15'd11520, 15'd0, 16'd0, 16'd0, 1, 1);
      send_tick(16'sd5, 16'sd5, 15'h7fff, 15'h7fff, 16'd1, 16'd2, 1, 0);
      send_tick(16'sd5, 16'sd5, 15'h7fff, 15'd0, 16'd1, 16'd2, 0, 1);
      send_tick(16'sd5, 16'sd5, 15'd100, 15'd150, 16'd1, 16'd2, 0, 0);
      // Small heading errors fall in the roll deadband.
      send_tick(16'sd0, 16'sd0, 15'd100, 15'd101, 16'd10, 16'd10, 1, 1);
      wait_drained();
      // Inverted pitch limits, then a half-turn and a zero roll limit.
      write_reg(RegPitchLimits, 48'({16'sh8000, 16'sh7fff}));
      write_reg(RegRollLimit, 48'd11520);
      send_tick(16'sd0, 16'sd0, 15'd0, 15'd5000, 16'd0, 16'd60000, 1, 1);
      send_tick(16'sd0, 16'sd0, 15'd0, 15'd5000, 16'd60000, 16'd0, 1, 1);
      wait_drained();
      write_reg(RegRollLimit, 48'd0);
      send_tick(16'sd0, 16'sd0, 15'd0, 15'd5000, 16'd0, 16'd0, 1, 1);
      wait_drained();
      // Manual mode gives zeros and holds state.
      write_reg(RegEngageMode, 48'd1);
      send_tick(16'sd300, 16'sd300, 15'd10, 15'd20, 16'd1, 16'd2, 1, 1);
      send_tick(16'sh8000, 16'sh7fff, 15'd10, 15'd20, 16'd1, 16'd2, 0, 0);
      wait_drained();
      write_reg(RegEngageMode, 48'd0);
      write_reg(RegPitchLimits, 48'(PitchLimitsReset));
      write_reg(RegRollLimit, 48'(RollLimitReset));
      send_tick(16'sd0, 16'sd0, 15'd10, 15'd20, 16'd1, 16'd2, 1, 1);
      wait_drained();
   endtask

   // One random phase with fresh registers; the extreme phase uses full-scale roll, pitch and yaw gains.
   task automatic test_random_phase(int n, bit extreme);
      write_reg(RegRollGains, extreme ? {16'sh7fff, 16'sh7fff, 16'sh8000} : rand_gains(8192));
      write_reg(RegPitchGains, extreme ? {16'sh8000, 16'sh8000, 16'sh7fff} : rand_gains(8192));
      write_reg(RegYawGains, extreme ? {16'sh7fff, 16'sh8000, 16'sh7fff} : rand_gains(8192));
      write_reg(RegAltGains, rand_gains(extreme ? 32768 : 2048));
      write_reg(RegHdgGains, rand_gains(extreme ? 32768 : 4096));
      write_reg(RegPitchLimits, $urandom_range(3) == 0 ? 48'($urandom)
                : 48'({16'($urandom_range(3000)), 16'(-$signed($urandom_range(3000)))}));
      write_reg(RegRollLimit, 48'($urandom_range(3) == 0 ? $urandom_range(16383)
                : $urandom_range(11520)));
      for (int i = 0; i < n; i++) send_random(1'b1);
      wait_drained();
   endtask

   task automatic test_manual_toggle();
      for (int i = 0; i < 40; i++) begin
         if (i % 10 == 0) begin
            wait_drained();
            write_reg(RegEngageMode, 48'(i % 20 == 0));
         end
         send_random(1'b0);
      end
      wait_drained();
      write_reg(RegEngageMode, 48'd0);
   endtask

   initial begin
      reset = 1'b1;
      fail_count = 0;
      send_idle_pct = 11;
      recv_idle_pct = 73;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      req_valid = 1'b0;
      req_pitch_meas = '0; req_roll_meas = '0; req_heading_meas = '0;
      req_bearing_cmd = '0; req_altitude_meas = '0; req_altitude_cmd = '0;
      req_nav_valid = 1'b0; req_alt_cmd_valid = 1'b0;
      reset_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phase(600, 1'b0);
      test_manual_toggle();
      send_idle_pct = 73;
      recv_idle_pct = 11;
      test_random_phase(600, 1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_phase(650, 1'b0);

      wait_drained();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire
